[hw/rtl/drle_pkg.sv]
// shared types and constants for the delta run-length encoder
`default_nettype none
package drle_pkg;

  localparam int unsigned DRLE_WORD_W     = 32;
  localparam int unsigned DRLE_BLOCK_MAX  = 4096;
  localparam int unsigned DRLE_QUEUE_DEPTH = 2;

  // slots of one transaction's result group, in output order
  localparam int unsigned SLOT_COUNT_PRE  = 0;
  localparam int unsigned SLOT_WORD       = 1;
  localparam int unsigned SLOT_COUNT_POST = 2;
  localparam int unsigned SLOT_N          = 3;

  // which results a sample produced, plus block end
  typedef struct packed {
    logic blk_end;
    logic has_post;
    logic has_word;
    logic has_pre;
  } drle_flags_t;

  localparam int unsigned DRLE_FLAGS_W = $bits(drle_flags_t);

endpackage
`default_nettype wire

[hw/rtl/delta_rle_encoder.sv]
// top level of the delta run-length encoder
// path: an accepted input transaction goes through the queue, then the output register
// throughput: one input transaction per cycle while out_stall is low and each yields at
//   most one result; a multi-result sample holds the single output register until done
// reset: synchronous active-low rst_n clears the queue, the output valid and run state;
//   the first sample after reset is treated as the raw start of a block
`default_nettype none
module delta_rle_encoder #(
  parameter int unsigned BLOCK_MAX = drle_pkg::DRLE_BLOCK_MAX
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input transactions
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_sample,
  input  wire logic               in_block_end,
  // result transactions
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_word,
  output logic                    out_word_is_count,
  output logic                    out_end_of_run,
  output logic                    out_end_of_block
);
  import drle_pkg::*;

  // repeat counts run from 0 up to BLOCK_MAX inclusive
  localparam int unsigned CNT_W = $clog2(BLOCK_MAX + 1);
  // one queue entry: flags, pre-count, word, post-count
  localparam int unsigned ENTRY_W = DRLE_FLAGS_W + CNT_W + DRLE_WORD_W + CNT_W;

  logic                   q_full, q_empty, q_pop, q_push;
  drle_flags_t            f_flags, h_flags;
  logic [CNT_W-1:0]       f_pre, f_post, h_pre, h_post;
  logic [DRLE_WORD_W-1:0] f_word, h_word;
  logic [ENTRY_W-1:0]     q_in, q_head;

  // front end: takes a sample per cycle unless the queue is full
  drle_front #(
    .BLOCK_MAX (BLOCK_MAX),
    .CNT_W     (CNT_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .in_block_end (in_block_end),
    .q_full       (q_full),
    .push         (q_push),
    .push_flags   (f_flags),
    .push_pre     (f_pre),
    .push_word    (f_word),
    .push_post    (f_post)
  );

  // samples absorbed into a run push nothing
  assign q_in = {f_flags, f_pre, f_word, f_post};

  drle_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (DRLE_QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head_data (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign {h_flags, h_pre, h_word, h_post} = q_head;

  // back end: serialises count / word / final count of each entry
  drle_back #(
    .CNT_W (CNT_W)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (!q_empty),
    .head_flags        (h_flags),
    .head_pre          (h_pre),
    .head_word         (h_word),
    .head_post         (h_post),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_word          (out_word),
    .out_word_is_count (out_word_is_count),
    .out_end_of_run    (out_end_of_run),
    .out_end_of_block  (out_end_of_block)
  );

endmodule
`default_nettype wire

[hw/rtl/drle_front.sv]
// front end: delta, run tracking and result grouping per sample
`default_nettype none
module drle_front #(
  parameter int unsigned BLOCK_MAX = drle_pkg::DRLE_BLOCK_MAX,
  parameter int unsigned CNT_W     = $clog2(BLOCK_MAX + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [31:0]      in_sample,
  input  wire logic                    in_block_end,
  input  wire logic                    q_full,
  output logic                         push,
  output drle_pkg::drle_flags_t        push_flags,
  output logic [CNT_W-1:0]             push_pre,
  output logic [drle_pkg::DRLE_WORD_W-1:0] push_word,
  output logic [CNT_W-1:0]             push_post
);
  import drle_pkg::*;

  logic [DRLE_WORD_W-1:0] prev_r, prev_nxt;
  logic [DRLE_WORD_W-1:0] last_r, last_nxt;
  logic                   hv_r, hv_nxt;
  logic                   counting_r, counting_nxt;
  logic [CNT_W-1:0]       rc_r, rc_nxt;
  logic                   start_r, start_nxt;

  logic                   accept;
  logic [DRLE_WORD_W-1:0] delta;
  logic                   pair;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign delta    = DRLE_WORD_W'(in_sample) - prev_r;

  always_comb begin
    prev_nxt     = prev_r;
    last_nxt     = last_r;
    hv_nxt       = hv_r;
    counting_nxt = counting_r;
    rc_nxt       = rc_r;
    start_nxt    = start_r;
    push_flags   = '0;
    push_pre     = rc_r;
    push_word    = delta;
    push_post    = '0;
    pair         = 1'b0;

    if (start_r) begin
      // raw first sample, not part of the history
      push_word           = DRLE_WORD_W'(in_sample);
      push_flags.has_word = 1'b1;
      prev_nxt            = DRLE_WORD_W'(in_sample);
      start_nxt           = 1'b0;
      hv_nxt              = 1'b0;
      counting_nxt        = 1'b0;
      rc_nxt              = '0;
    end else begin
      prev_nxt = DRLE_WORD_W'(in_sample);
      if (counting_r && delta == last_r && rc_r < CNT_W'(BLOCK_MAX)) begin
        rc_nxt = rc_r + CNT_W'(1);
      end else begin
        if (counting_r) begin
          // run broken or saturated: the count goes out first
          push_flags.has_pre = 1'b1;
          last_nxt           = DRLE_WORD_W'(rc_r);
          hv_nxt             = 1'b1;
          counting_nxt       = 1'b0;
          rc_nxt             = '0;
        end
        pair                = hv_nxt && (delta == last_nxt);
        push_flags.has_word = 1'b1;
        last_nxt            = delta;
        hv_nxt              = 1'b1;
        if (pair) begin
          counting_nxt = 1'b1;
          rc_nxt       = '0;
        end
      end
    end

    if (in_block_end) begin
      push_flags.blk_end = 1'b1;
      if (counting_nxt) begin
        push_flags.has_post = 1'b1;
        push_post           = rc_nxt;
      end
      last_nxt     = '0;
      hv_nxt       = 1'b0;
      counting_nxt = 1'b0;
      rc_nxt       = '0;
      start_nxt    = 1'b1;
    end
  end

  assign push = accept &&
                (push_flags.has_pre || push_flags.has_word || push_flags.has_post);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r     <= '0;
      last_r     <= '0;
      hv_r       <= 1'b0;
      counting_r <= 1'b0;
      rc_r       <= '0;
      start_r    <= 1'b1;
    end else if (accept) begin
      prev_r     <= prev_nxt;
      last_r     <= last_nxt;
      hv_r       <= hv_nxt;
      counting_r <= counting_nxt;
      rc_r       <= rc_nxt;
      start_r    <= start_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/drle_queue.sv]
// short fifo between front end and output sequencer
`default_nettype none
module drle_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      head_data,
  output logic                  full,
  output logic                  empty
);
  import drle_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign empty     = (cnt_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_data = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/drle_back.sv]
// back end: walks each result group out through the output register
`default_nettype none
module drle_back #(
  parameter int unsigned CNT_W = $clog2(drle_pkg::DRLE_BLOCK_MAX + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        head_valid,
  input  wire drle_pkg::drle_flags_t       head_flags,
  input  wire logic [CNT_W-1:0]            head_pre,
  input  wire logic [drle_pkg::DRLE_WORD_W-1:0] head_word,
  input  wire logic [CNT_W-1:0]            head_post,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [31:0]               out_word,
  output logic                             out_word_is_count,
  output logic                             out_end_of_run,
  output logic                             out_end_of_block
);
  import drle_pkg::*;

  logic [SLOT_N-1:0]      done_r, done_nxt;
  logic [SLOT_N-1:0]      pending;
  logic [SLOT_N-1:0]      pick;
  logic                   last;
  logic                   load;
  logic                   out_valid_r;
  logic [DRLE_WORD_W-1:0] word_r;
  logic                   is_count_r, eor_r, eob_r;
  logic [DRLE_WORD_W-1:0] sel_word;

  assign pending = {head_flags.has_post, head_flags.has_word, head_flags.has_pre} & ~done_r;

  // lowest pending slot goes next
  always_comb begin
    pick = '0;
    if (pending[SLOT_COUNT_PRE]) begin
      pick[SLOT_COUNT_PRE] = 1'b1;
    end else if (pending[SLOT_WORD]) begin
      pick[SLOT_WORD] = 1'b1;
    end else begin
      pick[SLOT_COUNT_POST] = 1'b1;
    end
  end

  assign last = ((pending & ~pick) == '0);
  assign load = head_valid && (!out_valid_r || !out_stall);
  assign pop  = load && last;

  always_comb begin
    if (pick[SLOT_COUNT_PRE]) begin
      sel_word = DRLE_WORD_W'(head_pre);
    end else if (pick[SLOT_WORD]) begin
      sel_word = head_word;
    end else begin
      sel_word = DRLE_WORD_W'(head_post);
    end
  end

  always_comb begin
    done_nxt = done_r;
    if (load) begin
      done_nxt = last ? '0 : (done_r | pick);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r     <= sel_word;
      is_count_r <= !pick[SLOT_WORD];
      eor_r      <= last;
      eob_r      <= last && head_flags.blk_end;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_word          = word_r;
  assign out_word_is_count = is_count_r;
  assign out_end_of_run    = eor_r;
  assign out_end_of_block  = eob_r;

endmodule
`default_nettype wire

[bench/tb_delta_rle_encoder.sv]
// self-checking testbench for the delta run-length encoder top level
`default_nettype none
module tb_delta_rle_encoder;
  import drle_pkg::*;

  localparam int unsigned RUN_MAX      = DRLE_BLOCK_MAX;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned SETTLE_TIME  = 10;
  localparam int unsigned RANDOM_ITEMS = 450;

  // one input transaction as queued for the driver
  typedef struct {
    logic [31:0] sample;
    logic        blk_end;
    logic        drain_first;  // hold back until every predicted word has come out
  } sample_item_t;

  // one encoded word as the block should emit it
  typedef struct {
    logic [31:0] word;
    logic        is_count;
    logic        run_end;
    logic        blk_end;
  } coded_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_sample = '0;
  logic               in_block_end = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_word;
  logic               out_word_is_count;
  logic               out_end_of_run;
  logic               out_end_of_block;

  sample_item_t sample_q[$];
  coded_word_t  encoded_q[$];

  // words_predicted is owned by the driver, words_checked by the monitor (nonblocking)
  int unsigned words_predicted = 0;
  int unsigned words_checked   = 0;
  int unsigned mismatches      = 0;
  int unsigned cycle_count     = 0;

  // predictor state, a copy of the encoder's own
  logic [31:0] prev_smp;
  logic [31:0] last_w;
  logic [1:0]  words_held;
  logic        in_run;
  logic [12:0] run_len;
  logic        blk_start;

  always #1 clk = ~clk;

  delta_rle_encoder i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .in_block_end      (in_block_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_word          (out_word),
    .out_word_is_count (out_word_is_count),
    .out_end_of_run    (out_end_of_run),
    .out_end_of_block  (out_end_of_block)
  );

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // every emitted word apart from the raw sample enters the two-word history
  function automatic void note_word(input logic [31:0] w);
    last_w = w;
    if (words_held < 2'd2) words_held = words_held + 2'd1;
  endfunction

  function automatic void push_word(input logic [31:0] w, input logic is_cnt);
    coded_word_t cw;
    cw.word     = w;
    cw.is_count = is_cnt;
    cw.run_end  = 1'b0;
    cw.blk_end  = 1'b0;
    encoded_q.push_back(cw);
  endfunction

  function automatic void flush_count();
    push_word({19'd0, run_len}, 1'b1);
    note_word({19'd0, run_len});
    in_run  = 1'b0;
    run_len = '0;
  endfunction

  // a delta equal to the word just before it opens a run with count 0
  function automatic void emit_delta(input logic [31:0] d);
    logic pair;
    pair = (words_held != 2'd0) && (d == last_w);
    push_word(d, 1'b0);
    note_word(d);
    if (pair) begin
      in_run  = 1'b1;
      run_len = '0;
    end
  endfunction

  // works out the words one accepted sample produces and queues them
  function automatic void encode_sample(input logic [31:0] smp, input logic blk_end);
    int unsigned n;
    logic [31:0] d;
    coded_word_t tail;
    n = 0;
    if (blk_start) begin
      push_word(smp, 1'b0);
      n          = 1;
      prev_smp   = smp;
      blk_start  = 1'b0;
      words_held = '0;
      in_run     = 1'b0;
      run_len    = '0;
    end else begin
      d        = smp - prev_smp;
      prev_smp = smp;
      if (in_run && d == last_w && run_len < RUN_MAX) begin
        // absorbed into the run, nothing emitted
        run_len = run_len + 13'd1;
      end else begin
        // run broken or saturated: pending count first, then the delta
        if (in_run) begin
          flush_count();
          n++;
        end
        emit_delta(d);
        n++;
      end
    end
    if (blk_end) begin
      // a pending count closes the block, even when it is still 0
      if (in_run) begin
        flush_count();
        n++;
      end
      last_w     = '0;
      words_held = '0;
      in_run     = 1'b0;
      run_len    = '0;
      blk_start  = 1'b1;
    end
    if (n > 0) begin
      tail         = encoded_q.pop_back();
      tail.run_end = 1'b1;
      tail.blk_end = blk_end;
      encoded_q.push_back(tail);
    end
    words_predicted += n;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: bursts of random length, random gaps, payload held while stalled
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    sample_item_t item;
    logic         next_valid;
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_sample    <= '0;
      in_block_end <= 1'b0;
      prev_smp     = '0;
      last_w       = '0;
      words_held   = '0;
      in_run       = 1'b0;
      run_len      = '0;
      blk_start    = 1'b1;
    end else if (!(in_valid && in_stall)) begin
      // transaction accepted at this edge: predict its words
      if (in_valid) encode_sample(in_sample, in_block_end);
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (sample_q.size() > 0 &&
                   !(sample_q[0].drain_first && words_checked != words_predicted)) begin
        item       = sample_q.pop_front();
        next_valid = 1'b1;
        in_sample    <= item.sample;
        in_block_end <= item.blk_end;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          // now and then a long stretch without any gap
          if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(40, 120);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 20);
            gap_left   = $urandom_range(0, 6);
          end
        end
      end
      in_valid <= next_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks every accepted result and drives its own stall pattern
  // ---------------------------------------------------------------------------
  int unsigned mon_cycles  = 0;
  int unsigned phase_left  = 0;
  int unsigned stall_pct   = 0;
  int unsigned hold_left   = 0;

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    coded_word_t exp_w;
    logic        stall_next;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      mon_cycles++;
      if (out_valid && !out_stall) begin
        if (encoded_q.size() == 0) begin
          $error("unexpected result transaction: word %0d", out_word);
          mismatches++;
        end else begin
          exp_w = encoded_q.pop_front();
          check_field("word", exp_w.word, out_word);
          check_field("word_is_count", {31'd0, exp_w.is_count}, {31'd0, out_word_is_count});
          check_field("end_of_run", {31'd0, exp_w.run_end}, {31'd0, out_end_of_run});
          check_field("end_of_block", {31'd0, exp_w.blk_end}, {31'd0, out_end_of_block});
          words_checked <= words_checked + 1;
        end
      end
      // long hold-offs so the encoder fills up and stalls its input
      if (mon_cycles == 300 || mon_cycles == 2500) hold_left = 60;
      else if (hold_left == 0 && $urandom_range(0, 999) == 0) hold_left = $urandom_range(20, 50);
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 80);
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2:    stall_pct = 30;
          3:    stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      phase_left--;
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        stall_next = ($urandom_range(0, 99) < stall_pct);
      end
      out_stall <= stall_next;
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  function automatic void add_item(input logic [31:0] smp, input logic blk_end,
                                   input logic drain_first);
    sample_item_t it;
    it.sample      = smp;
    it.blk_end     = blk_end;
    it.drain_first = drain_first;
    sample_q.push_back(it);
  endfunction

  initial begin
    int unsigned random_items;
    int unsigned blk_len;
    int unsigned mode;
    logic        did_saturate;
    logic [31:0] smp;
    logic [31:0] step;
    logic [31:0] step_alt;

    // wrap at the extremes, a run broken by a new delta, a zero-delta run closed by block end
    add_item(32'h7fff_ffff, 1'b0, 1'b0);
    add_item(32'h8000_0000, 1'b0, 1'b0);
    add_item(32'h8000_0001, 1'b0, 1'b0);
    add_item(32'h8000_0002, 1'b0, 1'b0);
    add_item(32'h8000_0003, 1'b0, 1'b0);
    add_item(32'h0000_0005, 1'b0, 1'b0);
    add_item(32'h0000_0005, 1'b0, 1'b0);
    add_item(32'h0000_0005, 1'b0, 1'b0);
    add_item(32'h0000_0005, 1'b1, 1'b0);
    // single-sample block
    add_item(32'hffff_ffff, 1'b1, 1'b0);
    // pair on the last sample leaves a count of 0 as the final word
    add_item(32'h0000_0000, 1'b0, 1'b0);
    add_item(32'h0000_000a, 1'b0, 1'b0);
    add_item(32'h0000_0014, 1'b1, 1'b0);
    // count of 0 followed by a zero delta forms a pair with the count
    add_item(32'h0000_0000, 1'b0, 1'b0);
    add_item(32'h0000_0003, 1'b0, 1'b0);
    add_item(32'h0000_0006, 1'b0, 1'b0);
    add_item(32'h0000_0006, 1'b0, 1'b0);
    add_item(32'h0000_0006, 1'b0, 1'b0);
    add_item(32'h0000_0007, 1'b1, 1'b0);
    // most negative delta
    add_item(32'h0000_0000, 1'b0, 1'b1);
    add_item(32'h8000_0000, 1'b1, 1'b0);

    random_items = 0;
    did_saturate = 1'b0;
    while (random_items < RANDOM_ITEMS) begin
      blk_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
      mode     = $urandom_range(0, 9);
      smp      = $urandom;
      step     = ($urandom_range(0, 2) == 0) ? $urandom : 32'($urandom_range(0, 6)) - 32'd3;
      step_alt = step + 32'($urandom_range(1, 3));
      for (int unsigned k = 0; k < blk_len; k++) begin
        if (mode < 2) begin
          // noise
          smp = $urandom;
        end else if (mode < 9) begin
          // runs of equal deltas, broken now and then
          if (k > 0 && $urandom_range(0, 4) == 0)
            step = ($urandom_range(0, 2) == 0) ? $urandom : 32'($urandom_range(0, 6)) - 32'd3;
          smp = smp + step;
        end else begin
          // alternating deltas, never a pair
          smp = smp + ((k % 2 == 1) ? step_alt : step);
        end
        add_item(smp, k == blk_len - 1, k == 0 && $urandom_range(0, 24) == 0);
        random_items++;
      end
      // one block long enough to saturate the count; the delta then pairs with that count
      if (!did_saturate && random_items >= 200) begin
        did_saturate = 1'b1;
        for (int unsigned k = 0; k <= RUN_MAX + 4; k++)
          add_item(32'(k * RUN_MAX), k == RUN_MAX + 4, k == 0);
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // sampled on the falling edge, clear of the clocked processes
    do @(negedge clk);
    while (sample_q.size() != 0 || in_valid || words_checked != words_predicted);
    repeat (SETTLE_TIME) @(negedge clk);

    if (mismatches == 0 && encoded_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
